// ===== hdl/wmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard mask matcher package
// Shared constants and types for the wildcard mask matcher cells and top.
// ----------------------------------------------------------------------------
package wmm_pkg;

	localparam int BYTE_W       = 8;
	localparam int CFG_DATA_W   = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int LEN_W        = 6;
	localparam int MASK_WORDS   = 4;
	localparam int MASK_MAX_DEF = 32;

	localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;
	localparam logic [BYTE_W-1:0] ANY_CHAR  = 8'h3F;
	localparam logic [BYTE_W-1:0] NUL_CHAR  = 8'h00;

	localparam logic [CFG_IDX_W-1:0] REG_MASK_LO     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_MID_LO = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_MID_HI = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HI     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_LENGTH = 3'd4;

	// Per-transaction control broadcast to every cell
	typedef struct packed {
		logic step;
		logic restart;
	} ctrl_t;

	// Signals handed from one cell to the next
	typedef struct packed {
		logic act;
		logic carry;
		logic adv;
	} link_t;

endpackage

// ===== hdl/wmm_name_if.sv =====
// ----------------------------------------------------------------------------
// Wildcard mask matcher name channel
// Valid/ready channel carrying one name byte or an end-of-name marker.
// ----------------------------------------------------------------------------
interface wmm_name_if;
	logic       valid;
	logic       ready;
	logic [7:0] name_byte;
	logic       end_of_name;

	modport source (output valid, output name_byte, output end_of_name, input ready);
	modport sink   (input valid, input name_byte, input end_of_name, output ready);
endinterface

// ===== hdl/wmm_result_if.sv =====
// ----------------------------------------------------------------------------
// Wildcard mask matcher result channel
// Valid/ready channel carrying one match flag per name.
// ----------------------------------------------------------------------------
interface wmm_result_if;
	logic valid;
	logic ready;
	logic matched;

	modport source (output valid, output matched, input ready);
	modport sink   (input valid, input matched, output ready);
endinterface

// ===== hdl/wmm_cell.sv =====
// ----------------------------------------------------------------------------
// Wildcard mask matcher cell
// Holds the live bit of one mask position, applies the star closure carried
// in from the previous cell and hands the advance term to the next cell.
// ----------------------------------------------------------------------------
module wmm_cell #(
	parameter logic LIVE_INIT = 1'b0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wmm_pkg::ctrl_t              ctrl,
	input  logic [wmm_pkg::BYTE_W-1:0]  mask_byte,
	input  logic [wmm_pkg::BYTE_W-1:0]  name_byte,
	input  logic                        len_ok,
	input  wmm_pkg::link_t              link_in,
	output wmm_pkg::link_t              link_out,
	output logic                        live,
	output logic                        end_hit
);
	import wmm_pkg::*;

	logic live_q;
	logic act;
	logic is_star;
	logic cur;
	logic hit;

	always_comb begin
		act      = link_in.act & len_ok & (mask_byte != NUL_CHAR);
		is_star  = (mask_byte == STAR_CHAR);
		cur      = live_q | link_in.carry;
		hit      = (mask_byte == ANY_CHAR) | (mask_byte == name_byte);
		link_out.act   = act;
		link_out.carry = cur & act & is_star;
		link_out.adv   = cur & act & ~is_star & hit;
		end_hit  = cur & link_in.act & ~act;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= LIVE_INIT;
		end else if (ctrl.restart) begin
			live_q <= LIVE_INIT;
		end else if (ctrl.step) begin
			live_q <= (cur & act & is_star) | link_in.adv;
		end
	end

	assign live = live_q;

endmodule

// ===== hdl/wildcard_mask_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// Wildcard mask matcher unit
// Streams file name bytes through a row of mask position cells and reports
// whether each closed name matches the configured wildcard mask.
// ----------------------------------------------------------------------------
// Throughput: one name byte or end marker per cycle while no match flag is
//   stalled on the result channel (star closure ripples along the cell row).
// Result: the match flag is registered and presented in the cycle after its end marker.
// Reset: mask words and length clear to zero, only position 0 is live and
//   the result register is empty.
module wildcard_mask_matcher_unit #(
	parameter int MASK_MAX = wmm_pkg::MASK_MAX_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [wmm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wmm_pkg::CFG_DATA_W-1:0]   cfg_data,
	wmm_name_if.sink                         name_in,
	wmm_result_if.source                     result_out
);
	import wmm_pkg::*;

	logic [CFG_DATA_W-1:0] mask_q [MASK_WORDS];
	logic [LEN_W-1:0]      mask_length_q;
	logic                  live_end_q;
	logic                  out_valid_q;
	logic                  matched_q;

	logic                  acc;
	logic                  acc_end;
	logic                  acc_byte;
	ctrl_t                 ctrl;
	link_t                 links [MASK_MAX+1];
	logic [MASK_MAX-1:0]   end_hits;
	logic [BYTE_W-1:0]     mask_byte_w [MASK_MAX];
	logic [MASK_MAX:0]     live_vec;
	logic                  match_now;

	assign name_in.ready = ~out_valid_q | result_out.ready;
	assign acc      = name_in.valid & name_in.ready;
	assign acc_end  = acc & name_in.end_of_name;
	assign acc_byte = acc & ~name_in.end_of_name;

	always_comb begin
		ctrl.step    = acc_byte;
		ctrl.restart = acc_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < MASK_WORDS; w++) begin
				mask_q[w] <= '0;
			end
			mask_length_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MASK_LO:     mask_q[0] <= cfg_data;
				REG_MASK_MID_LO: mask_q[1] <= cfg_data;
				REG_MASK_MID_HI: mask_q[2] <= cfg_data;
				REG_MASK_HI:     mask_q[3] <= cfg_data;
				REG_MASK_LENGTH: mask_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign links[0] = '{act: 1'b1, carry: 1'b0, adv: 1'b0};

	for (genvar i = 0; i < MASK_MAX; i++) begin : g_cell
		localparam logic LIVE_INIT = (i == 0) ? 1'b1 : 1'b0;

		assign mask_byte_w[i] = mask_q[i / 8][(i % 8) * BYTE_W +: BYTE_W];

		wmm_cell #(
			.LIVE_INIT (LIVE_INIT)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.mask_byte (mask_byte_w[i]),
			.name_byte (name_in.name_byte),
			.len_ok    (LEN_W'(i) < mask_length_q),
			.link_in   (links[i]),
			.link_out  (links[i+1]),
			.live      (live_vec[i]),
			.end_hit   (end_hits[i])
		);
	end

	// Terminal position past the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_end_q <= 1'b0;
		end else if (acc_end) begin
			live_end_q <= 1'b0;
		end else if (acc_byte) begin
			live_end_q <= links[MASK_MAX].adv;
		end
	end

	assign live_vec[MASK_MAX] = live_end_q;
	assign match_now = (|end_hits) |
		((live_end_q | links[MASK_MAX].carry) & links[MASK_MAX].act);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_end) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_end) begin
			matched_q <= match_now;
		end
	end

	assign result_out.valid   = out_valid_q;
	assign result_out.matched = matched_q;

`ifndef NO_ASSERTIONS
	a_result_follows_end: assert property (@(posedge clk) disable iff (!arst_n)
		acc_end |=> result_out.valid && (result_out.matched == $past(match_now)))
		else $error("match result not presented after end of name");

	a_restart_live: assert property (@(posedge clk) disable iff (!arst_n)
		acc_end |=> (live_vec == (MASK_MAX+1)'(1)))
		else $error("live set not restarted after end of name");

	a_no_accept_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(result_out.valid && !result_out.ready) |-> !name_in.ready)
		else $error("transaction accepted while result stalled");

	a_first_pos_star_only: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_byte && (mask_byte_w[0] != STAR_CHAR)) |=> !live_vec[0])
		else $error("position 0 live after a byte without a leading star");
`endif

endmodule
